@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define BEV_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BEV_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/bev_pkg.sv @@
// bev_pkg: types, codes and constants of the bounded encoder value block
// no dependencies
`default_nettype none

package bev_pkg;

    localparam int DataW    = 32;
    localparam int DetW     = 16;
    localparam int StepW    = 16;
    localparam int DeltaW   = 33;
    localparam int SpanW    = 33;
    localparam int CandW    = 34;
    localparam int DivSteps = 34;
    localparam int CntW     = $clog2(DivSteps);
    localparam int AddrW    = 4;
    localparam int ApbW     = 32;
    localparam int InDataW  = 48;
    localparam int OutDataW = 72;
    localparam int OutUserW = 3;

    localparam logic signed [DataW-1:0] BoundAReset = 32'sd0;
    localparam logic signed [DataW-1:0] BoundBReset = 32'sd127;
    localparam logic signed [StepW-1:0] StepReset   = 16'sd1;
    localparam logic signed [StepW-1:0] StepOne     = 16'sd1;

    localparam logic ModeClamp  = 1'b0;
    localparam logic ModeWrap   = 1'b1;
    localparam logic KindDetent = 1'b0;
    localparam logic KindLoad   = 1'b1;

    typedef enum logic [1:0] {
        REG_BOUND_A = 2'd0,
        REG_BOUND_B = 2'd1,
        REG_STEP    = 2'd2,
        REG_MODE    = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CHECK,
        ST_DIV,
        ST_FIX,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic signed [DataW-1:0] bound_a;
        logic signed [DataW-1:0] bound_b;
        logic signed [StepW-1:0] step;
        logic                    mode;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic mul;
        logic skip;
        logic add;
        logic check;
        logic div_step;
        logic fix;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic need_div;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ src/bev_regs.sv @@
// bev_regs: configuration register file behind the apb port
// depends on bev_pkg
`default_nettype none

module bev_regs (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire [bev_pkg::AddrW-1:0] paddr,
    input  wire [bev_pkg::ApbW-1:0]  pwdata,
    output logic [bev_pkg::ApbW-1:0] prdata,
    output logic                     pready,
    output bev_pkg::t_cfg            o_cfg
);
    import bev_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bound_a <= BoundAReset;
            r_cfg.bound_b <= BoundBReset;
            r_cfg.step    <= StepReset;
            r_cfg.mode    <= ModeClamp;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BOUND_A: r_cfg.bound_a <= pwdata;
                REG_BOUND_B: r_cfg.bound_b <= pwdata;
                REG_STEP:    r_cfg.step    <= pwdata[StepW-1:0];
                REG_MODE:    r_cfg.mode    <= pwdata[0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BOUND_A: prdata = r_cfg.bound_a;
            REG_BOUND_B: prdata = r_cfg.bound_b;
            REG_STEP:    prdata = {{(ApbW-StepW){r_cfg.step[StepW-1]}}, r_cfg.step};
            REG_MODE:    prdata = {{(ApbW-1){1'b0}}, r_cfg.mode};
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/bev_ctrl.sv @@
// bev_ctrl: sequencer for one item: multiply, add, range check, remainder, output
// depends on bev_pkg
`default_nettype none

module bev_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  bev_pkg::t_stat i_stat,
    output bev_pkg::t_cmd  o_cmd
);
    import bev_pkg::*;

    t_state           r_state, n_state;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             w_last;

    assign w_last = (r_cnt == CntW'(DivSteps - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_MUL;
            ST_MUL:    n_state = i_stat.skip ? ST_FINISH : ST_ADD;
            ST_ADD:    n_state = ST_CHECK;
            ST_CHECK:  n_state = i_stat.need_div ? ST_DIV : ST_FINISH;
            ST_DIV:    if (w_last) n_state = ST_FIX;
            ST_FIX:    n_state = ST_FINISH;
            ST_FINISH: if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_cnt      = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul  = 1'b1;
                o_cmd.skip = i_stat.skip;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = '0;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/bev_dp.sv @@
// bev_dp: value datapath, held value, bit-serial remainder and output register
// depends on bev_pkg
`default_nettype none

module bev_dp (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  bev_pkg::t_cfg               i_cfg,
    input  bev_pkg::t_cmd               i_cmd,
    output bev_pkg::t_stat              o_stat,
    input  wire                         i_kind,
    input  wire [bev_pkg::DetW-1:0]     i_detents,
    input  wire [bev_pkg::DataW-1:0]    i_load_value,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [bev_pkg::DataW-1:0]   o_current_value,
    output logic [bev_pkg::DeltaW-1:0]  o_value_delta,
    output logic                        o_changed,
    output logic                        o_wrapped,
    output logic                        o_clamped
);
    import bev_pkg::*;

    // item and bounds
    logic                     r_kind;
    logic signed [DetW-1:0]   r_det;
    logic signed [DataW-1:0]  r_load;
    logic signed [DataW-1:0]  r_lo, r_hi;
    logic [SpanW-1:0]         r_span;
    logic signed [DataW-1:0]  r_prod;
    logic signed [CandW-1:0]  r_cand;
    logic signed [DataW-1:0]  r_res;
    logic                     r_wrap, r_clamp;
    // remainder unit
    logic [CandW-1:0]         r_x;
    logic [SpanW-1:0]         r_rem;
    logic                     r_neg;
    // state and output word
    logic signed [DataW-1:0]  r_held;
    logic                     r_out_valid;
    logic [DataW-1:0]         r_cur;
    logic [DeltaW-1:0]        r_delta;
    logic                     r_changed, r_wrapped, r_clamped;

    logic signed [DataW-1:0]  w_lo, w_hi;
    logic signed [StepW-1:0]  w_step;
    logic                     w_below, w_above;
    logic signed [CandW-1:0]  w_x;
    logic [CandW-1:0]         w_t;
    logic [CandW-1:0]         w_t_sub;
    logic [SpanW-1:0]         w_off;
    logic signed [DeltaW-1:0] w_delta;

    assign w_lo    = (i_cfg.bound_a < i_cfg.bound_b) ? i_cfg.bound_a : i_cfg.bound_b;
    assign w_hi    = (i_cfg.bound_a < i_cfg.bound_b) ? i_cfg.bound_b : i_cfg.bound_a;
    assign w_step  = (i_cfg.step == '0) ? StepOne : i_cfg.step;
    assign w_below = r_cand < CandW'(r_lo);
    assign w_above = r_cand > CandW'(r_hi);
    assign w_x     = r_cand - CandW'(r_lo);
    assign w_t     = {r_rem, r_x[CandW-1]};
    assign w_t_sub = w_t - {1'b0, r_span};
    assign w_off   = (r_neg && (r_rem != '0)) ? (r_span - r_rem) : r_rem;
    assign w_delta = DeltaW'(r_res) - DeltaW'(r_held);

    assign o_stat.skip     = (r_kind == KindDetent) && (r_det == '0);
    assign o_stat.need_div = (i_cfg.mode == ModeWrap) && (w_below || w_above);
    assign o_stat.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_det   <= i_detents;
            r_load  <= i_load_value;
            r_lo    <= w_lo;
            r_hi    <= w_hi;
            r_wrap  <= 1'b0;
            r_clamp <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod <= DataW'(r_det * w_step);
            r_span <= SpanW'(r_hi) - SpanW'(r_lo) + SpanW'(1);
        end
        if (i_cmd.skip) begin
            r_res <= r_held;
        end
        if (i_cmd.add) begin
            if (r_kind == KindLoad) begin
                r_cand <= CandW'(r_load);
            end else begin
                r_cand <= CandW'(r_held) + CandW'(r_prod);
            end
        end
        if (i_cmd.check) begin
            r_rem <= '0;
            r_neg <= w_x[CandW-1];
            r_x   <= w_x[CandW-1] ? CandW'(-w_x) : CandW'(w_x);
            if (i_cfg.mode == ModeClamp) begin
                r_clamp <= w_below || w_above;
                priority if (w_below) begin
                    r_res <= r_lo;
                end else if (w_above) begin
                    r_res <= r_hi;
                end else begin
                    r_res <= r_cand[DataW-1:0];
                end
            end else if (!(w_below || w_above)) begin
                r_res <= r_cand[DataW-1:0];
            end else begin
                r_wrap <= 1'b1;
            end
        end
        if (i_cmd.div_step) begin
            r_x   <= {r_x[CandW-2:0], 1'b0};
            r_rem <= (w_t >= {1'b0, r_span}) ? w_t_sub[SpanW-1:0] : w_t[SpanW-1:0];
        end
        if (i_cmd.fix) begin
            r_res <= r_lo + w_off[DataW-1:0];
        end
        if (i_cmd.out_load) begin
            r_cur     <= r_res;
            r_delta   <= (r_kind == KindLoad) ? '0 : w_delta;
            r_changed <= (r_kind == KindDetent) && (r_res != r_held);
            r_wrapped <= (r_kind == KindDetent) && r_wrap;
            r_clamped <= (r_kind == KindDetent) && r_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_held      <= r_res;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_current_value = r_cur;
    assign o_value_delta   = r_delta;
    assign o_changed       = r_changed;
    assign o_wrapped       = r_wrapped;
    assign o_clamped       = r_clamped;

endmodule

`default_nettype wire

@@ src/bounded_encoder_value.sv @@
// bounded_encoder_value: top level, apb registers, sequencer and datapath
// depends on bev_pkg, bev_regs, bev_ctrl, bev_dp and assert_macros.svh
//
// usage
//   s_axis carries one word per item: tuser is the kind (apply detents or load),
//   tdata the detent count and the load value. m_axis returns one word per item:
//   the new value, the change and the changed, wrapped and clamped flags (all zero for a load).
//   the apb port holds both bounds, the step per detent and the boundary mode;
//   write it only while no item is in flight.
// sequence
//   one item at a time. each item passes capture, multiply, add, range check
//   and output load; an out-of-range item in wrap mode adds the bit-serial
//   remainder (34 steps plus the fix-up) after the check. zero detents go
//   from multiply straight to output load. the next item is taken back in idle.
// reset
//   synchronous, active low: value 0, bounds 0 and 127, step 1, clamp mode,
//   output empty.
// stall
//   the result waits in the output register; the next item is accepted and
//   worked on, and completes once that register is taken.
`default_nettype none
`include "assert_macros.svh"

module bounded_encoder_value (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // apb configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // detents[15:0], load_value[47:16]
    input  wire  [0:0]  s_axis_tuser,   // kind[0]
    // result words
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [71:0] m_axis_tdata,   // current_value[31:0], value_delta[64:32], zero[71:65]
    output logic [2:0]  m_axis_tuser    // changed[0], wrapped[1], clamped[2]
);
    import bev_pkg::*;

    t_cfg              w_cfg;
    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [DataW-1:0]  w_cur;
    logic [DeltaW-1:0] w_delta;
    logic              w_changed, w_wrapped, w_clamped;

    bev_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bev_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bev_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_kind          (s_axis_tuser[0]),
        .i_detents       (s_axis_tdata[DetW-1:0]),
        .i_load_value    (s_axis_tdata[DetW+DataW-1:DetW]),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_current_value (w_cur),
        .o_value_delta   (w_delta),
        .o_changed       (w_changed),
        .o_wrapped       (w_wrapped),
        .o_clamped       (w_clamped)
    );

    assign m_axis_tdata = {{(OutDataW-DataW-DeltaW){1'b0}}, w_delta, w_cur};
    assign m_axis_tuser = {w_clamped, w_wrapped, w_changed};

    `BEV_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken while busy")
    `BEV_ASSERT(a_flags_excl, m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2]), "wrapped and clamped both set")
    `BEV_ASSERT(a_changed, m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[64:32] != '0)), "changed flag disagrees with delta")

endmodule

`default_nettype wire

@@ verif/bev_value_checker.sv @@
`timescale 1ns / 100ps
// bev_value_checker: watches the apb, input and result channels of bounded_encoder_value,
// predicts each result word from its own copy of the registers and the held value
// depends on bev_pkg
module bev_value_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_psel,
    input  wire                          i_penable,
    input  wire                          i_pwrite,
    input  wire  [bev_pkg::AddrW-1:0]    i_paddr,
    input  wire  [bev_pkg::ApbW-1:0]     i_pwdata,
    input  wire                          i_pready,
    input  wire                          i_s_tvalid,
    input  wire                          i_s_tready,
    input  wire  [bev_pkg::InDataW-1:0]  i_s_tdata,   // detents[15:0], load_value[47:16]
    input  wire  [0:0]                   i_s_tuser,   // kind[0]
    input  wire                          i_m_tvalid,
    input  wire                          i_m_tready,
    input  wire  [bev_pkg::OutDataW-1:0] i_m_tdata,   // current_value[31:0], value_delta[64:32], zero[71:65]
    input  wire  [bev_pkg::OutUserW-1:0] i_m_tuser,   // changed[0], wrapped[1], clamped[2]
    output int                           o_fail_count,
    output int                           o_pending
);
    import bev_pkg::*;

    typedef struct {
        logic signed [DataW-1:0]  value;
        logic signed [DeltaW-1:0] delta;
        logic                     changed;
        logic                     wrapped;
        logic                     clamped;
    } t_result_word;

    logic signed [DataW-1:0] lim_a;
    logic signed [DataW-1:0] lim_b;
    logic signed [StepW-1:0] step_q;
    logic                    wrap_on;
    logic signed [DataW-1:0] level;
    t_result_word            value_q[$];
    int                      word_no;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("word %0d: %s is %0d, expected %0d", word_no, what, got, want);
        o_fail_count++;
    endtask

    // bring a candidate into [min,max] by clamping or by folding modulo the span
    function automatic logic signed [DataW-1:0] fold_into_range(input longint cand,
                                                                output logic hit_wrap,
                                                                output logic hit_clamp);
        longint lo;
        longint hi;
        longint span;
        longint folded;
        lo = (lim_a < lim_b) ? longint'(lim_a) : longint'(lim_b);
        hi = (lim_a < lim_b) ? longint'(lim_b) : longint'(lim_a);
        hit_wrap = 1'b0;
        hit_clamp = 1'b0;
        if (wrap_on == ModeClamp) begin
            if (cand < lo) begin
                hit_clamp = 1'b1;
                return lo[DataW-1:0];
            end
            if (cand > hi) begin
                hit_clamp = 1'b1;
                return hi[DataW-1:0];
            end
            return cand[DataW-1:0];
        end
        span = hi - lo + 1;
        hit_wrap = (cand < lo) || (cand > hi);
        folded = lo + ((cand - lo) % span + span) % span;
        return folded[DataW-1:0];
    endfunction

    function automatic t_result_word predict_value(input logic kind,
                                                   input logic signed [DetW-1:0] det,
                                                   input logic signed [DataW-1:0] load);
        t_result_word r;
        longint       prev;
        longint       per_detent;
        longint       diff;
        logic         w;
        logic         c;
        r.delta = '0;
        r.changed = 1'b0;
        r.wrapped = 1'b0;
        r.clamped = 1'b0;
        if (kind == KindLoad) begin
            level = fold_into_range(longint'(load), w, c);
        end else if (det != 0) begin
            prev = longint'(level);
            per_detent = (step_q == 0) ? 64'sd1 : longint'(step_q);
            level = fold_into_range(prev + longint'(det) * per_detent, w, c);
            diff = longint'(level) - prev;
            r.delta = diff[DeltaW-1:0];
            r.changed = (diff != 0);
            r.wrapped = w;
            r.clamped = c;
        end
        r.value = level;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result_word            want;
        logic signed [DataW-1:0]  got_value;
        logic signed [DeltaW-1:0] got_delta;
        if (!i_rst_n) begin
            lim_a = BoundAReset;
            lim_b = BoundBReset;
            step_q = StepReset;
            wrap_on = ModeClamp;
            level = '0;
            value_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_BOUND_A: lim_a = i_pwdata[DataW-1:0];
                    REG_BOUND_B: lim_b = i_pwdata[DataW-1:0];
                    REG_STEP:    step_q = i_pwdata[StepW-1:0];
                    REG_MODE:    wrap_on = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                value_q.push_back(predict_value(i_s_tuser[0], i_s_tdata[15:0],
                                                i_s_tdata[47:16]));
            if (i_m_tvalid && i_m_tready) begin
                got_value = i_m_tdata[31:0];
                got_delta = i_m_tdata[64:32];
                if (value_q.size() == 0) begin
                    report_mismatch("unexpected word, current_value", got_value, 0);
                end else begin
                    want = value_q.pop_front();
                    if (got_value != want.value)
                        report_mismatch("current_value", got_value, want.value);
                    if (got_delta != want.delta)
                        report_mismatch("value_delta", got_delta, want.delta);
                    if (i_m_tuser[0] != want.changed)
                        report_mismatch("changed", i_m_tuser[0], want.changed);
                    if (i_m_tuser[1] != want.wrapped)
                        report_mismatch("wrapped", i_m_tuser[1], want.wrapped);
                    if (i_m_tuser[2] != want.clamped)
                        report_mismatch("clamped", i_m_tuser[2], want.clamped);
                    if (i_m_tdata[71:65] != '0)
                        report_mismatch("padding", i_m_tdata[71:65], 0);
                end
                word_no++;
            end
        end
        o_pending = value_q.size();
    end

endmodule

@@ verif/tb_bounded_encoder_value.sv @@
`timescale 1ns / 100ps
// tb_bounded_encoder_value: clock, reset, apb setup and input words for bounded_encoder_value
// with random sender gaps and receiver stalls; depends on bev_pkg and bev_value_checker
module tb_bounded_encoder_value;
    import bev_pkg::*;

    localparam int QuietLimit = 1000;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrW-1:0]    paddr = '0;
    logic [ApbW-1:0]     pwdata = '0;
    logic [ApbW-1:0]     prdata;
    logic                pready;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [0:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [OutUserW-1:0] m_axis_tuser;

    int   fail_count;
    int   pending;
    logic s_took = 1'b0;
    logic m_took = 1'b0;
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    int   rx_hold = 0;
    int   quiet_cycles = 0;

    bounded_encoder_value u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bev_value_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        s_took <= s_axis_tvalid && s_axis_tready;
        m_took <= m_axis_tvalid && m_axis_tready;
    end

    // receiver: after each word taken, hold tready low for a drawn number of cycles
    always @(negedge i_clk) begin : rx_pacing
        int stall;
        if (m_took) begin
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold <= stall - 1;
            end
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QuietLimit) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_word(input logic kind, input logic signed [DetW-1:0] det,
                             input logic signed [DataW-1:0] load);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {load, det};
        s_axis_tuser <= kind;
        do @(negedge i_clk); while (!s_took);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [ApbW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic signed [DataW-1:0] a,
                                 input logic signed [DataW-1:0] b,
                                 input logic signed [StepW-1:0] st, input logic md);
        drain_results();
        cfg_write(REG_BOUND_A, a);
        cfg_write(REG_BOUND_B, b);
        cfg_write(REG_STEP, {{16{st[15]}}, st});
        cfg_write(REG_MODE, {31'b0, md});
        tx_calm <= ($urandom_range(0, 3) == 0);
        rx_calm <= ($urandom_range(0, 3) == 0);
    endtask

    initial begin
        logic signed [DataW-1:0] ba;
        logic signed [DataW-1:0] bb;
        logic signed [DataW-1:0] swap;
        logic signed [DataW-1:0] load;
        logic signed [DetW-1:0]  det;
        logic signed [StepW-1:0] st;
        logic                    kind;
        longint                  top_l;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: clamp to 0..127, one per detent
        push_word(KindDetent, 16'sd0, 32'($urandom));
        push_word(KindDetent, 16'sd1, 32'($urandom));
        push_word(KindDetent, 16'sd32767, 32'($urandom));
        push_word(KindDetent, -16'sd32768, 32'($urandom));
        push_word(KindLoad, 16'($urandom), -32'sd5);
        push_word(KindLoad, 16'($urandom), 32'sh7fff_ffff);
        push_word(KindLoad, 16'($urandom), 32'sd64);

        // full range with swapped bounds, most negative step, wrap
        apply_setting(32'sh7fff_ffff, 32'sh8000_0000, -16'sd32768, ModeWrap);
        push_word(KindDetent, 16'sd0, 32'($urandom));
        push_word(KindLoad, 16'($urandom), 32'sh8000_0000);
        push_word(KindDetent, 16'sd1, 32'($urandom));
        push_word(KindDetent, -16'sd32768, 32'($urandom));
        push_word(KindDetent, 16'sd32767, 32'($urandom));
        push_word(KindLoad, 16'($urandom), 32'sh7fff_ffff);

        apply_setting(32'sh7fff_ffff, 32'sh8000_0000, -16'sd32768, ModeClamp);
        push_word(KindDetent, -16'sd1, 32'($urandom));
        push_word(KindDetent, 16'sd1, 32'($urandom));

        // equal bounds, zero step; held value first lies outside the new range
        apply_setting(-32'sd7, -32'sd7, 16'sd0, ModeWrap);
        push_word(KindDetent, 16'sd0, 32'($urandom));
        push_word(KindDetent, 16'sd5, 32'($urandom));
        push_word(KindLoad, 16'($urandom), 32'sd100);
        apply_setting(-32'sd7, -32'sd7, 16'sd0, ModeClamp);
        push_word(KindDetent, -16'sd3, 32'($urandom));

        apply_setting(32'sd10, -32'sd10, 16'sd3, ModeWrap);
        push_word(KindDetent, 16'sd7, 32'($urandom));
        push_word(KindDetent, -16'sd32768, 32'($urandom));
        push_word(KindLoad, 16'($urandom), 32'sd11);

        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 3))
                0: begin
                    ba = $urandom;
                    top_l = longint'(ba) + $urandom_range(0, 300);
                    if (top_l > 64'sd2147483647)
                        top_l = 64'sd2147483647;
                    bb = top_l[31:0];
                end
                1: begin
                    ba = $urandom;
                    bb = $urandom;
                end
                2: begin
                    ba = 32'sh8000_0000;
                    bb = 32'sh7fff_ffff;
                end
                default: begin
                    ba = $urandom;
                    bb = ba;
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                swap = ba;
                ba = bb;
                bb = swap;
            end
            st = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8) - 4);
            apply_setting(ba, bb, st, $urandom_range(0, 1) == 1 ? ModeWrap : ModeClamp);
            for (int n = 0; n < 50; n++) begin
                kind = ($urandom_range(0, 3) == 0) ? KindLoad : KindDetent;
                det = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 16) - 8);
                case ($urandom_range(0, 2))
                    0: load = ba + 32'($urandom_range(0, 20)) - 32'sd10;
                    1: load = bb + 32'($urandom_range(0, 20)) - 32'sd10;
                    default: load = $urandom;
                endcase
                push_word(kind, det, load);
            end
        end

        drain_results();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
